>>> design/kfsl_pkg.sv
// Package for the keyframe segment lookup: sizes, function codes, controller
// states and the command/status structs between controller and datapath.
`default_nettype none
package kfsl_pkg;
  localparam int unsigned MaxKeys  = 64;
  localparam int unsigned KeyW     = $clog2(MaxKeys);
  localparam int unsigned CntW     = KeyW + 1;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned FracW    = FracBits + 1;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_TIME  = 1'b0,
    REG_KEY_COUNT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;   // latch input item
    logic load;      // write table entry
    logic mod_start;
    logic mod_step;
    logic rd;        // read entries at index and index+1
    logic adv;       // advance search index
    logic div_start;
    logic div_step;
    logic set_zero;  // result: zero time
    logic set_clamp; // result: clamp past end
    logic set_nf;    // result: not found / load
    logic set_seg;   // result: segment found
    logic out_load;  // move result to output register
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic is_query;
    logic t_zero;
    logic past_end;
    logic clamp;
    logic need_mod;
    logic mod_done;
    logic match;
    logic last_seg;  // no more segments to test
    logic span_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

>>> design/kfsl_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on kfsl_pkg.
`default_nettype none
interface kfsl_in_if import kfsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [KeyW-1:0]  key_index;
  logic [TimeW-1:0] key_time;
  logic [TimeW-1:0] query_time;
  logic             wrap;
  modport source (output valid, func, key_index, key_time, query_time, wrap, input ready);
  modport sink   (input valid, func, key_index, key_time, query_time, wrap, output ready);
endinterface

interface kfsl_out_if import kfsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KeyW-1:0]  first_key;
  logic [KeyW-1:0]  second_key;
  logic [FracW-1:0] fraction;
  logic             found;
  modport source (output valid, first_key, second_key, fraction, found, input ready);
  modport sink   (input valid, first_key, second_key, fraction, found, output ready);
endinterface

interface kfsl_cfg_if import kfsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/kfsl_ctrl.sv
// Controller state machine for the keyframe segment lookup.
// Depends on kfsl_pkg; drives cmd_t, reads stat_t.
`default_nettype none
module kfsl_ctrl import kfsl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  out_busy_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i && !out_busy_i) state_d = ST_OUT;
      ST_OUT: begin
        // item was captured: pick path from captured fields
        if (!stat_i.is_query || stat_i.t_zero || stat_i.clamp) state_d = ST_IDLE;
        else if (stat_i.need_mod) state_d = ST_MOD;
        else state_d = ST_RD;
      end
      ST_MOD: if (stat_i.mod_done) state_d = ST_RD;
      ST_RD:  state_d = ST_CMP;
      ST_CMP: begin
        if (stat_i.match) state_d = stat_i.span_zero ? ST_IDLE : ST_DIV;
        else if (stat_i.last_seg) state_d = ST_IDLE;
        else state_d = ST_RD;
      end
      ST_DIV: if (stat_i.div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_busy_i;
        cmd_o.capture = in_valid_i && !out_busy_i;
      end
      ST_OUT: begin
        if (!stat_i.is_query) begin
          cmd_o.load = 1'b1;
          cmd_o.set_nf = 1'b1;
          cmd_o.out_load = 1'b1;
        end else if (stat_i.t_zero) begin
          cmd_o.set_zero = 1'b1;
          cmd_o.out_load = 1'b1;
        end else if (stat_i.clamp) begin
          cmd_o.set_clamp = 1'b1;
          cmd_o.out_load = 1'b1;
        end else if (stat_i.need_mod) begin
          cmd_o.mod_start = 1'b1;
        end
      end
      ST_MOD: cmd_o.mod_step = 1'b1;
      ST_RD:  cmd_o.rd = 1'b1;
      ST_CMP: begin
        if (stat_i.match) begin
          if (stat_i.span_zero) begin
            cmd_o.set_seg = 1'b1;
            cmd_o.out_load = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end else if (stat_i.last_seg) begin
          cmd_o.set_nf = 1'b1;
          cmd_o.out_load = 1'b1;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.set_seg = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> design/kfsl_dpath.sv
// Datapath: key table memory, config registers, restoring modulo and
// fraction dividers, search index and output register. Depends on kfsl_pkg.
`default_nettype none
module kfsl_dpath import kfsl_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TimeW-1:0] cfg_data_i,
  input  wire logic             func_i,
  input  wire logic [KeyW-1:0]  key_index_i,
  input  wire logic [TimeW-1:0] key_time_i,
  input  wire logic [TimeW-1:0] query_time_i,
  input  wire logic             wrap_i,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [KeyW-1:0]       first_key_o,
  output logic [KeyW-1:0]       second_key_o,
  output logic [FracW-1:0]      fraction_o,
  output logic                  found_o
);
  localparam int unsigned ModCntW = $clog2(TimeW + 1);
  localparam int unsigned DivBits = TimeW + FracBits;
  localparam int unsigned DivCntW = $clog2(DivBits + 1);

  logic [TimeW-1:0] max_time_q;
  logic [CntW-1:0]  key_count_q;
  logic [TimeW-1:0] key_mem [MaxKeys];

  logic             func_q, wrap_q;
  logic [KeyW-1:0]  kidx_q;
  logic [TimeW-1:0] ktime_q, t_q;

  logic [TimeW-1:0]   rem_q;
  logic [TimeW-1:0]   quo_q;   // shifting dividend
  logic [ModCntW-1:0] mcnt_q;

  logic [KeyW-1:0]  idx_q;
  logic [TimeW-1:0] lo_q, hi_q;

  logic [DivBits-1:0] dnum_q;
  logic [TimeW:0]     drem_q;
  logic [FracW-1:0]   dquo_q;
  logic [DivCntW-1:0] dcnt_q;

  logic             ovalid_q;
  logic [KeyW-1:0]  ofirst_q, osecond_q;
  logic [FracW-1:0] ofrac_q;
  logic             ofound_q;

  logic [CntW-1:0] n_use;
  logic [KeyW-1:0] last_key;
  logic [TimeW:0]  mtry, dtry;

  always_comb begin
    n_use = key_count_q;
    if (n_use == '0) n_use = CntW'(1);
    if (n_use > CntW'(MaxKeys)) n_use = CntW'(MaxKeys);
    last_key = KeyW'(n_use - CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q  <= '0;
      key_count_q <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_TIME:  max_time_q  <= cfg_data_i;
        REG_KEY_COUNT: key_count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      wrap_q  <= wrap_i;
      kidx_q  <= key_index_i;
      ktime_q <= key_time_i;
      t_q     <= query_time_i;
    end else if (cmd_i.mod_step && mcnt_q == '0) begin
      t_q <= rem_q;
    end
  end

  // Table: one write port, two registered reads at the search index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_mem[kidx_q] <= ktime_q;
    if (cmd_i.rd) begin
      lo_q <= key_mem[idx_q];
      hi_q <= key_mem[idx_q + KeyW'(1)];
    end
  end

  // Restoring remainder, one bit a cycle.
  assign mtry = {rem_q, quo_q[TimeW-1]} - {1'b0, max_time_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      rem_q  <= '0;
      quo_q  <= t_q;
      mcnt_q <= ModCntW'(TimeW);
    end else if (cmd_i.mod_step && mcnt_q != '0) begin
      rem_q  <= mtry[TimeW] ? {rem_q[TimeW-2:0], quo_q[TimeW-1]} : mtry[TimeW-1:0];
      quo_q  <= {quo_q[TimeW-2:0], 1'b0};
      mcnt_q <= mcnt_q - ModCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) idx_q <= '0;
    else if (cmd_i.adv) idx_q <= idx_q + KeyW'(1);
  end

  // Fraction: (t-lo)<<16 / span, one bit a cycle; quotient fits in 17 bits.
  assign dtry = {drem_q[TimeW-1:0], dnum_q[DivBits-1]} - {1'b0, hi_q - lo_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dnum_q <= {t_q - lo_q, {FracBits{1'b0}}};
      drem_q <= '0;
      dquo_q <= '0;
      dcnt_q <= DivCntW'(DivBits);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      drem_q <= dtry[TimeW] ? {drem_q[TimeW-1:0], dnum_q[DivBits-1]} : dtry;
      dquo_q <= {dquo_q[FracW-2:0], ~dtry[TimeW]};
      dnum_q <= {dnum_q[DivBits-2:0], 1'b0};
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  always_comb begin
    stat_o.is_query  = (func_q == FUNC_QUERY);
    stat_o.t_zero    = (t_q == '0);
    stat_o.past_end  = (t_q >= max_time_q);
    stat_o.clamp     = stat_o.past_end && (!wrap_q || max_time_q == '0);
    stat_o.need_mod  = stat_o.past_end;
    stat_o.mod_done  = cmd_i.mod_step && (mcnt_q == '0);
    stat_o.match     = (lo_q <= t_q) && (t_q < hi_q) && (idx_q < last_key);
    stat_o.last_seg  = (KeyW'(idx_q + KeyW'(1)) >= last_key) || (last_key == '0);
    stat_o.span_zero = (hi_q == lo_q);
    stat_o.div_done  = (dcnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ofirst_q  <= '0;
      osecond_q <= '0;
      ofrac_q   <= '0;
      ofound_q  <= 1'b0;
      if (cmd_i.set_zero) ofound_q <= 1'b1;
      if (cmd_i.set_clamp) begin
        ofirst_q  <= last_key;
        osecond_q <= last_key;
        ofrac_q   <= FracW'(1) << FracBits;
        ofound_q  <= 1'b1;
      end
      if (cmd_i.set_seg) begin
        ofirst_q  <= idx_q;
        osecond_q <= idx_q + KeyW'(1);
        ofrac_q   <= cmd_i.div_step ? dquo_q : '0;
        ofound_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o  = ovalid_q;
  assign first_key_o  = ofirst_q;
  assign second_key_o = osecond_q;
  assign fraction_o   = ofrac_q;
  assign found_o      = ofound_q;
endmodule
`default_nettype wire

>>> design/keyframe_segment_lookup.sv
// Keyframe segment lookup: one item at a time. A load is captured, then
// written to the table with its result in ST_OUT. A query ends in ST_OUT
// for time zero or clamp; else it runs the one-bit-a-cycle modulo when
// wrapping, then the linear search (a read and a compare per segment, up to
// 63 segments), then the serial fraction divider unless the span is zero.
// The result register lets the next item wait only until the result is taken.
// Depends on kfsl_pkg, kfsl_if, kfsl_ctrl and kfsl_dpath.
`default_nettype none
module keyframe_segment_lookup import kfsl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kfsl_in_if.sink   in_if,
  kfsl_out_if.source out_if,
  kfsl_cfg_if.sink  cfg_if
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_if.ready = 1'b1;

  kfsl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_if.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kfsl_dpath u_dpath (
    .clk_i, .rst_ni,
    .cfg_we_i     (cfg_if.valid),
    .cfg_idx_i    (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .func_i       (in_if.func),
    .key_index_i  (in_if.key_index),
    .key_time_i   (in_if.key_time),
    .query_time_i (in_if.query_time),
    .wrap_i       (in_if.wrap),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_if.ready),
    .out_valid_o  (out_if.valid),
    .first_key_o  (out_if.first_key),
    .second_key_o (out_if.second_key),
    .fraction_o   (out_if.fraction),
    .found_o      (out_if.found)
  );

  // A new item only enters when no result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> !out_if.valid)
    else $error("item accepted with result pending");

  // Each accepted item produces a result before the next is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("ready reasserted before item finished");

  // Only a found result carries a nonzero fraction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.found) |-> (out_if.fraction == '0))
    else $error("fraction set without found");
endmodule
`default_nettype wire

>>> bench/kfsl_tb_if.sv
// Interface instances are taken from the design file kfsl_if.sv; this file only
// groups the shared testbench item and result types. Depends on kfsl_pkg.
`default_nettype none
package kfsl_tb_pkg;
  import kfsl_pkg::*;

  typedef struct packed {
    func_e             func;
    logic [KeyW-1:0]   key_index;
    logic [TimeW-1:0]  key_time;
    logic [TimeW-1:0]  query_time;
    logic              wrap;
  } lookup_item_t;

  typedef struct packed {
    logic [KeyW-1:0]   first_key;
    logic [KeyW-1:0]   second_key;
    logic [FracW-1:0]  fraction;
    logic              found;
  } segment_t;
endpackage
`default_nettype wire

>>> bench/tb.sv
// Testbench for keyframe_segment_lookup: random and directed load/query items,
// an in-bench segment predictor and an in-order result check.
// Depends on kfsl_pkg, kfsl_if, kfsl_tb_pkg and the RTL.
`default_nettype none
module tb;
  import kfsl_pkg::*;
  import kfsl_tb_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  kfsl_in_if  in_if ();
  kfsl_out_if out_if ();
  kfsl_cfg_if cfg_if ();

  keyframe_segment_lookup u_top (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_if (in_if.sink), .out_if (out_if.source), .cfg_if (cfg_if.sink)
  );

  // predictor state
  logic [TimeW-1:0] key_table [MaxKeys];
  logic [TimeW-1:0] cur_max_time;
  logic [6:0]       cur_key_count;

  lookup_item_t pending_items[$];
  segment_t     expected_segments[$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  int unsigned  queries_sent = 0;
  int unsigned  idle_cycles = 0;
  bit           quiet = 1'b0;     // no idling in the last part
  bit           sender_hold = 1'b0;
  int unsigned  sink_hold_cycles = 0;
  int unsigned  src_gap = 0;
  int unsigned  snk_gap = 0;

  function automatic segment_t predict_segment(lookup_item_t it);
    segment_t r;
    logic [TimeW-1:0] t;
    int unsigned last;
    logic [63:0] num;
    r = '0;
    if (it.func == FUNC_LOAD) begin
      key_table[it.key_index] = it.key_time;
      return r;
    end
    t = it.query_time;
    if (t == 0) begin
      r.found = 1'b1;
      return r;
    end
    last = (cur_key_count == 0) ? 0 :
           (cur_key_count > MaxKeys) ? MaxKeys - 1 : cur_key_count - 1;
    if (t >= cur_max_time) begin
      if (!it.wrap || cur_max_time == 0) begin
        r.first_key  = last[KeyW-1:0];
        r.second_key = last[KeyW-1:0];
        r.fraction   = 17'h10000;
        r.found      = 1'b1;
        return r;
      end
      t = t % cur_max_time;
    end
    for (int unsigned i = 0; i < last; i++) begin
      if (key_table[i] <= t && t < key_table[i+1]) begin
        num = {32'd0, t - key_table[i]} << FracBits;
        r.first_key  = i[KeyW-1:0];
        r.second_key = KeyW'(i + 1);
        r.fraction   = FracW'(num / (key_table[i+1] - key_table[i]));
        r.found      = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  // source driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.func <= FUNC_LOAD;
      in_if.key_index <= '0;
      in_if.key_time <= '0;
      in_if.query_time <= '0;
      in_if.wrap <= 1'b0;
      src_gap <= 0;
    end else begin
      automatic bit take_next = !in_if.valid || in_if.ready;
      if (in_if.valid && in_if.ready)
        expected_segments.push_back(predict_segment(lookup_item_t'({in_if.func,
          in_if.key_index, in_if.key_time, in_if.query_time, in_if.wrap})));
      if (take_next) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (!sender_hold && pending_items.size() > 0) begin
          automatic lookup_item_t it = pending_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= it.func;
          in_if.key_index <= it.key_index;
          in_if.key_time <= it.key_time;
          in_if.query_time <= it.query_time;
          in_if.wrap <= it.wrap;
          if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap <= 0;
      idle_cycles <= 0;
    end else begin
      automatic bit hit = out_if.valid && out_if.ready;
      if (hit) begin
        automatic segment_t got = {out_if.first_key, out_if.second_key,
                                   out_if.fraction, out_if.found};
        results_seen <= results_seen + 1;
        if (expected_segments.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          automatic segment_t exp_s = expected_segments.pop_front();
          if (got.first_key !== exp_s.first_key || got.second_key !== exp_s.second_key ||
              got.fraction !== exp_s.fraction || got.found !== exp_s.found) begin
            $display("%0t: mismatch expected k%0d-k%0d f%0d found%0d, actual k%0d-k%0d f%0d found%0d",
                     $time, exp_s.first_key, exp_s.second_key, exp_s.fraction, exp_s.found,
                     got.first_key, got.second_key, got.fraction, got.found);
            errors <= errors + 1;
          end
        end
      end
      if (hit || (in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles <= sink_hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) snk_gap <= $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_segments.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [TimeW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_MAX_TIME) cur_max_time = value;
    else cur_key_count = value[6:0];
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (in_if.valid || expected_segments.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic lookup_item_t make_load(int unsigned idx, logic [TimeW-1:0] tm);
    lookup_item_t it = '0;
    it.func = FUNC_LOAD;
    it.key_index = idx[KeyW-1:0];
    it.key_time = tm;
    it.query_time = $urandom;
    it.wrap = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic lookup_item_t make_query(logic [TimeW-1:0] t, logic w);
    lookup_item_t it = '0;
    it.func = FUNC_QUERY;
    it.key_index = KeyW'($urandom);
    it.key_time = $urandom;
    it.query_time = t;
    it.wrap = w;
    return it;
  endfunction

  // Fill all 64 entries ascending (with random duplicates and times spread up to top).
  task automatic load_table(logic [TimeW-1:0] top);
    logic [TimeW-1:0] tm;
    logic [TimeW-1:0] step;
    tm = 0;
    step = top / MaxKeys;
    for (int unsigned i = 0; i < MaxKeys; i++) begin
      pending_items.push_back(make_load(i, tm));
      if ($urandom_range(0, 7) != 0) tm = tm + $urandom_range(1, step == 0 ? 1 : step);
    end
  endtask

  task automatic random_queries(int unsigned n, logic [TimeW-1:0] span);
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(make_query($urandom, 1'($urandom_range(0, 1))));
        1: pending_items.push_back(make_query(32'd0, 1'($urandom_range(0, 1))));
        2: pending_items.push_back(make_load($urandom_range(0, MaxKeys - 1),
                                             key_table[$urandom_range(0, MaxKeys - 1)]));
        default: pending_items.push_back(make_query($urandom_range(0, span),
                                                    1'($urandom_range(0, 1))));
      endcase
      queries_sent++;
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MAX_TIME;
    cfg_if.data = '0;
    cur_max_time = '0;
    cur_key_count = 7'd1;
    foreach (key_table[i]) key_table[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full table, extremes of every field
    load_table(32'h0400_0000);
    drain();
    write_reg(REG_MAX_TIME, 32'h0100_0000);
    write_reg(REG_KEY_COUNT, 32'd64);
    pending_items.push_back(make_load(63, 32'hFFFF_FFFF));
    pending_items.push_back(make_query(32'd0, 1'b0));
    pending_items.push_back(make_query(32'h0000_0001, 1'b0));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 1'b0));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_query(32'h0100_0000, 1'b1));
    pending_items.push_back(make_query(32'h00FF_FFFF, 1'b1));
    pending_items.push_back(make_query(32'h0000_8000, 1'b1));
    drain();
    write_reg(REG_MAX_TIME, 32'd0);
    write_reg(REG_KEY_COUNT, 32'd0);
    pending_items.push_back(make_query(32'h1234_5678, 1'b1));
    pending_items.push_back(make_query(32'h0000_0001, 1'b0));
    drain();
    write_reg(REG_KEY_COUNT, 32'd127);
    write_reg(REG_MAX_TIME, 32'hFFFF_FFFF);
    pending_items.push_back(make_query(32'hFFFF_FFFE, 1'b1));
    pending_items.push_back(make_query(32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_query(32'h8000_0000, 1'b0));
    drain();

    // random phases with varied settings
    for (int unsigned ph = 0; ph < 6; ph++) begin
      automatic logic [TimeW-1:0] top = (ph % 2) ? 32'hFFFF_FFFF : $urandom_range(64, 32'h0010_0000);
      load_table(top);
      drain();
      write_reg(REG_KEY_COUNT, (ph == 0) ? 32'd2 : $urandom_range(1, 64));
      write_reg(REG_MAX_TIME, (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(1, top));
      if (ph == 2) begin
        // long receiver hold while the sender keeps offering items
        sink_hold_cycles = 1500;
        random_queries(20, top);
        drain();
        // sender pause until every expected result has arrived
        sender_hold = 1'b1;
        wait (expected_segments.size() == 0);
        sender_hold = 1'b0;
      end
      if (ph == 5) quiet = 1'b1;
      random_queries(245, top + (top >> 3));
      drain();
    end

    repeat (300) @(posedge clk_i);
    $display("Covered %0d results over 6 random table setups, clamp, wrap, zero and", results_seen);
    $display("not-found queries, with stalls on both sides.");
    if (errors == 0 && expected_segments.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/kfsl_pkg.sv
design/kfsl_if.sv
design/kfsl_ctrl.sv
design/kfsl_dpath.sv
design/keyframe_segment_lookup.sv
bench/kfsl_tb_if.sv
bench/tb.sv
